/* sv/base_n_string_to_integer_macros.svh */
// Assertion macros for the radix string parser.
// Used by the top level; no other dependencies.
`ifndef BASE_N_STRING_TO_INTEGER_MACROS_SVH
`define BASE_N_STRING_TO_INTEGER_MACROS_SVH

`ifndef SYNTH
`define BNSI_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("%m: check failed");
`define BNSI_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: check failed");
`else
`define BNSI_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define BNSI_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

/* sv/bnsi_pkg.sv */
// Shared types and constants for the radix string parser.
// No dependencies.
`timescale 1ns / 1ps

package bnsi_pkg;

    localparam int SYMBOLS_LIMIT = 16;
    localparam int SYMS_PER_WORD = 8;
    localparam int CHAR_W        = 8;
    localparam int SYM_IDX_W     = 4;
    localparam int RADIX_W       = 5;
    localparam int OUT_VALUE_W   = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef logic [CHAR_W-1:0] sym_t;

    typedef enum logic [1:0] {
        PH_SPACES,
        PH_SIGNS,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic                 hit;
        logic [SYM_IDX_W-1:0] idx;
    } match_t;

    typedef struct packed {
        logic signed [OUT_VALUE_W-1:0] value;
        logic                          base_invalid;
        logic                          overflow;
    } result_t;

endpackage

/* sv/bnsi_cfg.sv */
// Configuration registers: alphabet symbols, clamped radix, alphabet validity flag.
// Depends on bnsi_pkg.
`timescale 1ns / 1ps

module bnsi_cfg #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bnsi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bnsi_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bnsi_pkg::sym_t                      symbols [MAX_SYMBOLS],
    output logic [bnsi_pkg::RADIX_W-1:0]        radix,
    output logic                                base_invalid
);
    import bnsi_pkg::*;

    sym_t               sym_reg [MAX_SYMBOLS];
    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] len_clamped;
    logic               invalid_flag;

    assign len_clamped = (cfg_data[RADIX_W-1:0] > RADIX_W'(MAX_SYMBOLS))
                         ? RADIX_W'(MAX_SYMBOLS) : cfg_data[RADIX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_SYMBOLS; k++)
            begin
                sym_reg[k] <= '0;
            end
            radix_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYMBOLS_LOW:
                begin
                    for (int k = 0; k < MAX_SYMBOLS; k++)
                    begin
                        if (k < SYMS_PER_WORD)
                        begin
                            sym_reg[k] <= cfg_data[(k % SYMS_PER_WORD) * CHAR_W +: CHAR_W];
                        end
                    end
                end
                CFG_SYMBOLS_HIGH:
                begin
                    for (int k = 0; k < MAX_SYMBOLS; k++)
                    begin
                        if (k >= SYMS_PER_WORD)
                        begin
                            sym_reg[k] <= cfg_data[(k % SYMS_PER_WORD) * CHAR_W +: CHAR_W];
                        end
                    end
                end
                CFG_BASE_LENGTH:
                begin
                    radix_reg <= len_clamped;
                end
                default:
                begin
                    radix_reg <= radix_reg;
                end
            endcase
        end
    end

    // flag short alphabets, sign or space symbols, and repeats
    always_comb
    begin
        invalid_flag = (radix_reg < RADIX_W'(2));
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (RADIX_W'(i) < radix_reg)
            begin
                if (sym_reg[i] == CHAR_PLUS || sym_reg[i] == CHAR_MINUS ||
                    sym_reg[i] == CHAR_SPACE)
                begin
                    invalid_flag = 1'b1;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if (RADIX_W'(j) < radix_reg && sym_reg[j] == sym_reg[i])
                    begin
                        invalid_flag = 1'b1;
                    end
                end
            end
        end
    end

    assign symbols      = sym_reg;
    assign radix        = radix_reg;
    assign base_invalid = invalid_flag;

endmodule

/* sv/bnsi_match.sv */
// Parallel symbol compare with lowest-index priority.
// Depends on bnsi_pkg.
`timescale 1ns / 1ps

module bnsi_match #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic [bnsi_pkg::CHAR_W-1:0]  char_code,
    input  bnsi_pkg::sym_t               symbols [MAX_SYMBOLS],
    input  logic [bnsi_pkg::RADIX_W-1:0] radix,
    output bnsi_pkg::match_t             match
);
    import bnsi_pkg::*;

    always_comb
    begin
        match.hit = 1'b0;
        match.idx = '0;
        for (int k = MAX_SYMBOLS - 1; k >= 0; k--)
        begin
            if (RADIX_W'(k) < radix && symbols[k] == char_code)
            begin
                match.hit = 1'b1;
                match.idx = SYM_IDX_W'(k);
            end
        end
    end

endmodule

/* sv/bnsi_core.sv */
// Parse state machine and accumulator: one character per step, multiply-add per digit.
// Depends on bnsi_pkg.
`timescale 1ns / 1ps

module bnsi_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [bnsi_pkg::CHAR_W-1:0]  char_code,
    input  logic                         end_of_string,
    input  bnsi_pkg::match_t             match,
    input  logic [bnsi_pkg::RADIX_W-1:0] radix,
    input  logic                         base_invalid,
    output bnsi_pkg::result_t            result
);
    import bnsi_pkg::*;

    localparam int PROD_W = VALUE_WIDTH + RADIX_W;
    localparam logic [PROD_W-1:0] LIMIT = PROD_W'({1'b0, {(VALUE_WIDTH-1){1'b1}}});

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [VALUE_WIDTH-1:0]   acc_reg;
    logic [VALUE_WIDTH-1:0]   acc_next;
    logic                     minus_reg;
    logic                     minus_next;
    logic                     ovf_reg;
    logic                     ovf_next;

    logic                     is_nul;
    logic                     is_space;
    logic                     is_minus;
    logic                     is_sign;
    logic                     take_digit;
    logic                     toggle;
    logic                     grow;
    logic [PROD_W-1:0]        prod;
    logic [VALUE_WIDTH-1:0]   signed_mag;

    assign is_nul   = (char_code == CHAR_NUL);
    assign is_space = (char_code == CHAR_SPACE);
    assign is_minus = (char_code == CHAR_MINUS);
    assign is_sign  = is_minus || (char_code == CHAR_PLUS);

    assign take_digit = !is_nul &&
                        ((phase_reg == PH_SPACES && !is_space && !is_sign) ||
                         (phase_reg == PH_SIGNS && !is_sign) ||
                         (phase_reg == PH_DIGITS));
    assign toggle = !is_nul && is_minus &&
                    (phase_reg == PH_SPACES || phase_reg == PH_SIGNS);
    assign grow   = take_digit && match.hit;

    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            if (end_of_string)
            begin
                phase_next = PH_SPACES;
            end
            else if (is_nul)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SPACES:
                    begin
                        if (is_sign)
                        begin
                            phase_next = PH_SIGNS;
                        end
                        else if (!is_space)
                        begin
                            phase_next = match.hit ? PH_DIGITS : PH_DONE;
                        end
                    end
                    PH_SIGNS:
                    begin
                        if (!is_sign)
                        begin
                            phase_next = match.hit ? PH_DIGITS : PH_DONE;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (!match.hit)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        prod       = PROD_W'(acc_reg) * PROD_W'(radix) + PROD_W'(match.idx);
        acc_next   = grow ? prod[VALUE_WIDTH-1:0] : acc_reg;
        minus_next = minus_reg ^ toggle;
        ovf_next   = ovf_reg | (grow && (prod > LIMIT));
        signed_mag = minus_next ? (~acc_next + VALUE_WIDTH'(1)) : acc_next;

        result.base_invalid = base_invalid;
        result.value        = base_invalid ? '0 : OUT_VALUE_W'(signed'(signed_mag));
        result.overflow     = !base_invalid && ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACES;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (step)
            begin
                if (end_of_string)
                begin
                    acc_reg   <= '0;
                    minus_reg <= 1'b0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    acc_reg   <= acc_next;
                    minus_reg <= minus_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

endmodule

/* sv/base_n_string_to_integer.sv */
// Top level of the radix string parser: input register, parse core, result register.
// Depends on bnsi_pkg, bnsi_cfg, bnsi_match, bnsi_core and the assertion macro header.
`timescale 1ns / 1ps
`include "base_n_string_to_integer_macros.svh"

// Takes one character per beat and sustains one beat per cycle, but an
// end-of-string beat is held in the input register while the output register
// is full and m_tready is low. A character waits in the input register while
// it is matched against the alphabet and folded into the accumulator by a
// single multiply-add; on the beat marked by s_tlast the result is written to
// the output register as that beat leaves the input register. The accumulator
// multiply-add is the one loop that sets the cycle. The configuration port is
// always ready; write it only while no beat is in flight. m_tuser flags an
// unusable alphabet (value then 0) and a wrapped result.
module base_n_string_to_integer #(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bnsi_pkg::CHAR_W-1:0]         s_tdata,   // [7:0] char_code
    input  logic                                s_tlast,   // end_of_string
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bnsi_pkg::OUT_VALUE_W-1:0]    m_tdata,   // [31:0] value
    output logic [1:0]                          m_tuser,   // [0] base_invalid, [1] overflow
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bnsi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bnsi_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bnsi_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [CHAR_W-1:0]  in_char_reg;
    logic               in_eos_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_reg;

    logic               s_accept;
    logic               advance;

    sym_t               symbols [MAX_SYMBOLS];
    logic [RADIX_W-1:0] radix;
    logic               base_invalid;
    match_t             match;
    result_t            result;

    assign cfg_ready = 1'b1;

    bnsi_cfg #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .symbols      (symbols),
        .radix        (radix),
        .base_invalid (base_invalid)
    );

    bnsi_match #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_match (
        .char_code (in_char_reg),
        .symbols   (symbols),
        .radix     (radix),
        .match     (match)
    );

    bnsi_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .char_code     (in_char_reg),
        .end_of_string (in_eos_reg),
        .match         (match),
        .radix         (radix),
        .base_invalid  (base_invalid),
        .result        (result)
    );

    // hold an end-of-string beat while the result slot is full and m_tready is low
    assign advance  = in_valid_reg && (!in_eos_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && in_eos_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_char_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
        if (advance && in_eos_reg)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.value;
    assign m_tuser[0] = out_reg.base_invalid;
    assign m_tuser[1] = out_reg.overflow;

    `BNSI_ASSERT_NEXT(a_eos_gives_result, clk, rst_n, advance && in_eos_reg, m_tvalid)
    `BNSI_ASSERT_NEXT(a_input_held, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    `BNSI_ASSERT_IMPLIES(a_invalid_zero, clk, rst_n, m_tvalid && m_tuser[0], m_tdata == '0 && !m_tuser[1])

endmodule

/* tb/tb_top.sv */
// Self-checking bench for base_n_string_to_integer: streams characters, predicts each parsed value.
// Depends on bnsi_pkg and the base_n_string_to_integer top level only.
`timescale 1ns / 1ps

module tb_top;

    import bnsi_pkg::*;

    localparam int unsigned ITEM_TARGET  = 1300;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE  = 2'd3;
    localparam logic [CFG_DATA_W-1:0] DIGITS_LO  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DATA_W-1:0] DECIMAL_HI = 64'h0000_0000_0000_3938;
    localparam logic [CFG_DATA_W-1:0] HEX_HI     = 64'h6665_6463_6261_3938;

    typedef enum int {
        ALPHA_DECIMAL,
        ALPHA_HEX,
        ALPHA_RANDOM,
        ALPHA_BROKEN
    } alpha_flavor_t;

    typedef struct {
        sym_t        code;
        logic        last;
        int unsigned gap;
    } char_beat_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [CHAR_W-1:0]      s_tdata   = '0;   // [7:0] char_code
    logic                   s_tlast   = 1'b0; // end_of_string
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_VALUE_W-1:0] m_tdata;          // [31:0] value
    logic [1:0]             m_tuser;          // [0] base_invalid, [1] overflow
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Parser model: alphabet registers and parse state.
    logic [CFG_DATA_W-1:0]  alpha_lo  = '0;
    logic [CFG_DATA_W-1:0]  alpha_hi  = '0;
    logic [RADIX_W-1:0]     alpha_len = '0;
    phase_t                 parse_state = PH_SPACES;
    logic [OUT_VALUE_W-1:0] magnitude = '0;
    logic                   negate    = 1'b0;
    logic                   wrapped   = 1'b0;

    char_beat_t  char_queue[$];
    result_t     parsed_values[$];

    int unsigned trailing_gap  = 0;
    int unsigned gap_left      = 0;
    int unsigned stall_left    = 0;
    bit          sink_mode     = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned failures      = 0;
    int unsigned beats_queued  = 0;
    int unsigned values_seen   = 0;
    int unsigned wraps_seen    = 0;
    int unsigned invalid_seen  = 0;
    int unsigned writes_done   = 0;

    base_n_string_to_integer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned radix_of();
        return (alpha_len > RADIX_W'(SYMBOLS_LIMIT)) ? SYMBOLS_LIMIT : alpha_len;
    endfunction

    function automatic sym_t symbol(input int unsigned k);
        return (k < SYMS_PER_WORD) ? alpha_lo[k*8 +: 8] : alpha_hi[(k-SYMS_PER_WORD)*8 +: 8];
    endfunction

    function automatic int digit_value(input sym_t ch);
        for (int k = 0; k < radix_of(); k++)
        begin
            if (symbol(k) == ch)
                return k;
        end
        return -1;
    endfunction

    function automatic bit alphabet_ok();
        int unsigned n;
        n = radix_of();
        if (n < 2)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (symbol(i) == CHAR_SPACE || symbol(i) == CHAR_PLUS || symbol(i) == CHAR_MINUS)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
            begin
                if (symbol(j) == symbol(i))
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic fold_char(input sym_t ch, input logic last);
        int              d;
        longint unsigned r;
        longint unsigned limit;
        result_t         res;
        if (ch == CHAR_NUL)
            parse_state = PH_DONE;
        else
        begin
            if (parse_state == PH_SPACES && ch != CHAR_SPACE)
                parse_state = PH_SIGNS;
            if (parse_state == PH_SIGNS)
            begin
                if (ch == CHAR_MINUS)
                    negate = ~negate;
                else if (ch != CHAR_PLUS)
                    parse_state = PH_DIGITS;
            end
            if (parse_state == PH_DIGITS)
            begin
                d = digit_value(ch);
                if (d < 0)
                    parse_state = PH_DONE;
                else
                begin
                    r = radix_of();
                    limit = 64'h7FFF_FFFF;
                    if (!wrapped && magnitude > (limit - longint'(d)) / r)
                        wrapped = 1'b1;
                    magnitude = OUT_VALUE_W'(magnitude * r + longint'(d));
                end
            end
        end
        if (last)
        begin
            if (!alphabet_ok())
            begin
                res.value        = '0;
                res.base_invalid = 1'b1;
                res.overflow     = 1'b0;
            end
            else
            begin
                res.value        = negate ? -magnitude : magnitude;
                res.base_invalid = 1'b0;
                res.overflow     = wrapped;
            end
            parsed_values.push_back(res);
            parse_state = PH_SPACES;
            magnitude   = '0;
            negate      = 1'b0;
            wrapped     = 1'b0;
        end
    endtask

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sym_t stray_char(input int unsigned digits);
        case ($urandom_range(0, 5))
            0: return CHAR_NUL;
            1: return CHAR_SPACE;
            2: return CHAR_PLUS;
            3: return CHAR_MINUS;
            4: return (digits != 0) ? symbol($urandom_range(0, digits - 1)) : CHAR_NUL;
            default: return sym_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic flag_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    task automatic send(input sym_t code, input bit last, input bit calm);
        char_beat_t beat;
        beat.code = code;
        beat.last = last;
        beat.gap  = (calm || $urandom_range(0, 99) >= 30) ? 0 : idle_span();
        char_queue.push_back(beat);
        beats_queued++;
    endtask

    task automatic push_word(input string s, input bit calm);
        for (int i = 0; i < s.len(); i++)
            send(s[i], i == s.len() - 1, calm);
    endtask

    task automatic queue_string(input bit tidy, input bit calm);
        sym_t        text[$];
        int unsigned digits;
        int unsigned count;
        digits = radix_of();
        if (tidy)
        begin
            repeat ($urandom_range(0, 3)) text.push_back(CHAR_SPACE);
            repeat ($urandom_range(0, 3))
                text.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 36) : $urandom_range(1, 9);
            repeat (count)
            begin
                if (digits == 0)
                    text.push_back(sym_t'($urandom_range(0, 255)));
                else
                    text.push_back(symbol($urandom_range(0, digits - 1)));
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) text.push_back(stray_char(digits));
        end
        else
            repeat ($urandom_range(1, 8)) text.push_back(stray_char(digits));
        foreach (text[i])
            send(text[i], i == text.size() - 1, calm);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SYMBOLS_LOW:  alpha_lo  = data;
            CFG_SYMBOLS_HIGH: alpha_hi  = data;
            CFG_BASE_LENGTH:  alpha_len = data[RADIX_W-1:0];
            default: ;
        endcase
        writes_done++;
    endtask

    task automatic load_alphabet(input alpha_flavor_t flavor);
        sym_t                  pool[SYMBOLS_LIMIT];
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] len_word;
        int unsigned           len;
        int unsigned           span;
        int unsigned           k;
        int unsigned           j;
        bit                    clash;
        for (k = 0; k < SYMBOLS_LIMIT; k++)
        begin
            clash = 1'b1;
            while (clash)
            begin
                pool[k] = sym_t'($urandom_range(0, 255));
                clash = (pool[k] == CHAR_SPACE || pool[k] == CHAR_PLUS || pool[k] == CHAR_MINUS);
                for (j = 0; j < k; j++)
                begin
                    if (pool[j] == pool[k])
                        clash = 1'b1;
                end
            end
        end
        len  = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 31) : $urandom_range(2, 16);
        span = (len > SYMBOLS_LIMIT) ? SYMBOLS_LIMIT : len;
        case (flavor)
            ALPHA_DECIMAL:
            begin
                for (k = 0; k < 10; k++)
                    pool[k] = sym_t'(8'h30 + k);
                len = 10;
            end
            ALPHA_HEX:
            begin
                for (k = 0; k < SYMBOLS_LIMIT; k++)
                    pool[k] = (k < 10) ? sym_t'(8'h30 + k) : sym_t'(8'h61 + k - 10);
                len = SYMBOLS_LIMIT;
            end
            ALPHA_BROKEN:
            begin
                k = $urandom_range(0, span - 1);
                case ($urandom_range(0, 4))
                    0: len = $urandom_range(0, 1);
                    1: pool[k] = CHAR_SPACE;
                    2: pool[k] = CHAR_PLUS;
                    3: pool[k] = CHAR_MINUS;
                    default:
                    begin
                        j = $urandom_range(0, span - 1);
                        if (j == k)
                            j = (k + 1) % span;
                        pool[k] = pool[j];
                    end
                endcase
            end
            default: ;
        endcase
        for (k = 0; k < SYMS_PER_WORD; k++)
        begin
            lo[k*8 +: 8] = pool[k];
            hi[k*8 +: 8] = pool[k+SYMS_PER_WORD];
        end
        len_word = {$urandom, $urandom};
        len_word[RADIX_W-1:0] = len[RADIX_W-1:0];
        set_register(CFG_SYMBOLS_LOW, lo);
        set_register(CFG_SYMBOLS_HIGH, hi);
        set_register(CFG_BASE_LENGTH, len_word);
    endtask

    task automatic wait_drained();
        while (char_queue.size() != 0 || s_tvalid || parsed_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Source side: present queued characters, hold each beat until taken.
    always @(posedge clk)
    begin
        char_beat_t beat;
        logic       fire;
        if (rst_n)
        begin
            fire = s_tvalid && s_tready;
            if (fire)
                fold_char(s_tdata, s_tlast);
            if (!s_tvalid || fire)
            begin
                if (fire && trailing_gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= trailing_gap - 1;
                end
                else if (!fire && gap_left != 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (char_queue.size() != 0)
                begin
                    beat = char_queue.pop_front();
                    s_tvalid     <= 1'b1;
                    s_tdata      <= beat.code;
                    s_tlast      <= beat.last;
                    trailing_gap <= beat.gap;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: check each result beat, stall at random.
    always @(posedge clk)
    begin
        result_t want;
        logic    ready_next;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                values_seen++;
                if (m_tuser[1])
                    wraps_seen++;
                if (m_tuser[0])
                    invalid_seen++;
                if (parsed_values.size() == 0)
                    flag_failure($sformatf("unexpected result: value %0d flags %b",
                                           $signed(m_tdata), m_tuser));
                else
                begin
                    want = parsed_values.pop_front();
                    if (want.value !== m_tdata || want.base_invalid !== m_tuser[0]
                        || want.overflow !== m_tuser[1])
                        flag_failure($sformatf({"mismatch: expected value %0d invalid %b ",
                                                "overflow %b, got value %0d invalid %b overflow %b"},
                                               want.value, want.base_invalid, want.overflow,
                                               $signed(m_tdata), m_tuser[0], m_tuser[1]));
                end
            end
            if (sink_mode)
                ready_next = 1'b1;
            else if (stall_left != 0)
            begin
                ready_next = 1'b0;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                ready_next = 1'b0;
                stall_left <= idle_span() - 1;
            end
            else
                ready_next = 1'b1;
            m_tready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, parsed_values.size());
            $display("** base_n_string_to_integer: FAILED **");
            $finish;
        end
    end

    initial
    begin
        alpha_flavor_t flavor;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        set_register(CFG_SYMBOLS_LOW, DIGITS_LO);
        set_register(CFG_SYMBOLS_HIGH, DECIMAL_HI);
        set_register(CFG_BASE_LENGTH, 64'd10);
        set_register(CFG_SPARE, {$urandom, $urandom});
        push_word(" -+-42", 1'b0);
        push_word("7x9", 1'b0);
        send("5", 1'b0, 1'b0);
        send(CHAR_NUL, 1'b0, 1'b0);
        send("3", 1'b1, 1'b0);
        send(8'hFF, 1'b1, 1'b1);
        wait_drained();

        set_register(CFG_SYMBOLS_HIGH, HEX_HI);
        set_register(CFG_BASE_LENGTH, '1);
        push_word("-80000000", 1'b0);
        send("1", 1'b0, 1'b0);
        wait_drained();
        // shrink the radix in the middle of a string
        set_register(CFG_BASE_LENGTH, 64'd2);
        send("1", 1'b1, 1'b0);
        wait_drained();
        set_register(CFG_BASE_LENGTH, 64'd1);
        send("0", 1'b1, 1'b0);
        wait_drained();

        set_register(CFG_SYMBOLS_LOW, '1);
        set_register(CFG_SYMBOLS_HIGH, '1);
        set_register(CFG_BASE_LENGTH, '1);
        repeat (6) queue_string(1'b1, 1'b0);
        wait_drained();
        set_register(CFG_SYMBOLS_LOW, '0);
        set_register(CFG_SYMBOLS_HIGH, '0);
        set_register(CFG_BASE_LENGTH, '0);
        repeat (6) queue_string(1'b0, 1'b0);
        wait_drained();

        while (beats_queued < ITEM_TARGET)
        begin
            case ($urandom_range(0, 19))
                0, 1:    flavor = ALPHA_DECIMAL;
                2, 3:    flavor = ALPHA_HEX;
                4, 5, 6, 7, 8: flavor = ALPHA_BROKEN;
                default: flavor = ALPHA_RANDOM;
            endcase
            load_alphabet(flavor);
            sink_mode = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(8, 20))
                queue_string($urandom_range(0, 4) != 0, $urandom_range(0, 3) == 0);
            wait_drained();
        end

        if (parsed_values.size() != 0)
            flag_failure($sformatf("%0d results never arrived", parsed_values.size()));
        $display("Sent %0d characters and checked %0d parsed values over %0d register writes;",
                 beats_queued, values_seen, writes_done);
        $display("%0d values wrapped, %0d came from an unusable alphabet, %0d failures.",
                 wraps_seen, invalid_seen, failures);
        if (failures == 0)
            $display("** base_n_string_to_integer: PASSED **");
        else
            $display("** base_n_string_to_integer: FAILED **");
        $finish;
    end

endmodule
